/* hdl/ultrasonic_echo_ranger_top_assert.svh */
// Assertion macros for the ultrasonic echo ranger checker.
// Used by uer_checker.sv; needs nothing else.
`ifndef ULTRASONIC_ECHO_RANGER_TOP_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UER_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/uer_pkg.sv */
// Shared types, constants and helpers for the ultrasonic echo ranger.
// No dependencies; every other file but the assertion header imports this package.
package uer_pkg;

  // Width of the microsecond counter.
  localparam int COUNT_WIDTH = 16;
  localparam int CMP_W       = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int DIV_CNT_W   = $clog2(COUNT_WIDTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIVISOR_W  = 8;
  localparam int DIST_W     = 16;
  localparam int STATUS_W   = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_TO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_US_PER_CM  = 3'd4;

  // Register reset values.
  localparam logic [7:0]  LEAD_LOW_RST   = 8'd8;
  localparam logic [7:0]  TRIG_WIDTH_RST = 8'd15;
  localparam logic [15:0] START_TO_RST   = 16'd3000;
  localparam logic [15:0] ECHO_TO_RST    = 16'd23200;
  localparam logic [DIVISOR_W-1:0] US_PER_CM_RST = 8'd58;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ECHO   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ECHO_LONG = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // Measurement phases, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_LEAD  = 6'b000010,
    PH_PULSE = 6'b000100,
    PH_RISE  = 6'b001000,
    PH_HIGH  = 6'b010000,
    PH_DIV   = 6'b100000
  } phase_t;

  // Operations on the elapsed counter.
  typedef enum logic [1:0] {
    CNT_HOLD  = 2'd0,
    CNT_INC   = 2'd1,
    CNT_CLEAR = 2'd2,
    CNT_ONE   = 2'd3
  } cnt_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    cnt_op_t             cnt_op;
    logic                div_start;
    logic                out_load;
    logic                res_trig;
    logic                res_busy;
    logic                res_done;
    logic [STATUS_W-1:0] res_status;
    logic                res_quot;
  } dp_cmd_t;

  // Compare results and divider status from the datapath.
  typedef struct packed {
    logic lead_zero;
    logic lead_hit;
    logic pulse_hit;
    logic rise_to;
    logic high_to;
    logic first_to;
    logic div_done;
  } dp_status_t;

  // Clamp a quotient to the distance field.
  function automatic logic [DIST_W-1:0] sat_dist(input logic [COUNT_WIDTH-1:0] q);
    logic [31:0] q32;
    q32 = 32'(q);
    if (q32 > 32'h0000_FFFF) begin
      return '1;
    end
    return q32[DIST_W-1:0];
  endfunction

endpackage

/* hdl/uer_if.sv */
// Valid/ready channel interfaces for the request and result sides.
// Depends on uer_pkg for payload widths.
interface uer_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic echo_level;

  modport source (output valid, cmd, echo_level, input ready);
  modport sink   (input valid, cmd, echo_level, output ready);
endinterface

interface uer_out_if import uer_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                trigger_level;
  logic                busy_res;
  logic                done_res;
  logic [STATUS_W-1:0] status;
  logic [DIST_W-1:0]   distance_cm;

  modport source (output valid, trigger_level, busy_res, done_res, status, distance_cm,
                  input ready);
  modport sink   (input valid, trigger_level, busy_res, done_res, status, distance_cm,
                  output ready);
endinterface

/* hdl/uer_ctrl.sv */
// Ranging controller: measurement phase machine and channel handshakes.
// Depends on uer_pkg; drives uer_dp through dp_cmd_t.
module uer_ctrl import uer_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_cmd,
  input  logic       in_echo,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    dp_cmd,
  input  dp_status_t dp_status
);

  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  // A request is taken when no division runs and the result slot frees up.
  assign in_ready  = (phase_r != PH_DIV) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Phase transitions and datapath commands.
  always_comb begin
    phase_nxt = phase_r;
    dp_cmd    = '0;
    dp_cmd.cnt_op = CNT_HOLD;
    if (phase_r == PH_DIV) begin
      if (dp_status.div_done) begin
        phase_nxt         = PH_IDLE;
        dp_cmd.cnt_op     = CNT_CLEAR;
        dp_cmd.out_load   = 1'b1;
        dp_cmd.res_done   = 1'b1;
        dp_cmd.res_status = ST_OK;
        dp_cmd.res_quot   = 1'b1;
      end
    end else if (in_fire) begin
      if (in_cmd) begin
        // A start only counts when idle.
        if (phase_r == PH_IDLE) begin
          dp_cmd.cnt_op = CNT_CLEAR;
          phase_nxt     = dp_status.lead_zero ? PH_PULSE : PH_LEAD;
        end
      end else begin
        case (phase_r)
          PH_IDLE: begin
            phase_nxt = PH_IDLE;
          end
          PH_LEAD: begin
            if (dp_status.lead_hit) begin
              phase_nxt     = PH_PULSE;
              dp_cmd.cnt_op = CNT_CLEAR;
            end else begin
              dp_cmd.cnt_op = CNT_INC;
            end
          end
          PH_PULSE: begin
            if (dp_status.pulse_hit) begin
              phase_nxt     = PH_RISE;
              dp_cmd.cnt_op = CNT_CLEAR;
            end else begin
              dp_cmd.cnt_op = CNT_INC;
            end
          end
          PH_RISE: begin
            if (in_echo) begin
              if (dp_status.first_to) begin
                phase_nxt         = PH_IDLE;
                dp_cmd.cnt_op     = CNT_CLEAR;
                dp_cmd.res_done   = 1'b1;
                dp_cmd.res_status = ST_ECHO_LONG;
              end else begin
                phase_nxt     = PH_HIGH;
                dp_cmd.cnt_op = CNT_ONE;
              end
            end else if (dp_status.rise_to) begin
              phase_nxt         = PH_IDLE;
              dp_cmd.cnt_op     = CNT_CLEAR;
              dp_cmd.res_done   = 1'b1;
              dp_cmd.res_status = ST_NO_ECHO;
            end else begin
              dp_cmd.cnt_op = CNT_INC;
            end
          end
          PH_HIGH: begin
            if (in_echo) begin
              if (dp_status.high_to) begin
                phase_nxt         = PH_IDLE;
                dp_cmd.cnt_op     = CNT_CLEAR;
                dp_cmd.res_done   = 1'b1;
                dp_cmd.res_status = ST_ECHO_LONG;
              end else begin
                dp_cmd.cnt_op = CNT_INC;
              end
            end else begin
              // Echo fell: divide the count before reporting.
              phase_nxt        = PH_DIV;
              dp_cmd.div_start = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      dp_cmd.out_load = (phase_nxt != PH_DIV);
      dp_cmd.res_trig = (phase_nxt == PH_PULSE);
      dp_cmd.res_busy = (phase_nxt != PH_IDLE);
    end
  end

  // The result slot fills on a load and empties when taken.
  always_comb begin
    if (dp_cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/uer_dp.sv */
// Ranging datapath: registers, elapsed counter, compares, serial divider, result.
// Depends on uer_pkg; commanded by uer_ctrl.
module uer_dp import uer_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  dp_cmd_t               dp_cmd,
  output dp_status_t            dp_status,
  output logic                  res_trigger_level,
  output logic                  res_busy,
  output logic                  res_done,
  output logic [STATUS_W-1:0]   res_status,
  output logic [DIST_W-1:0]     res_distance_cm
);

  logic [7:0]           lead_low_r;
  logic [7:0]           trig_width_r;
  logic [15:0]          start_to_r;
  logic [15:0]          echo_to_r;
  logic [DIVISOR_W-1:0] us_per_cm_r;

  logic [COUNT_WIDTH-1:0] elapsed_r, elapsed_nxt, elapsed_inc;

  logic                   div_busy_r;
  logic [DIV_CNT_W-1:0]   div_cnt_r;
  logic [COUNT_WIDTH-1:0] quo_r;
  logic [DIVISOR_W-1:0]   rem_r;
  logic [DIVISOR_W:0]     rem_sh, rem_diff;
  logic                   rem_ge;

  logic                   trig_r, busy_r, done_r;
  logic [STATUS_W-1:0]    status_r;
  logic [DIST_W-1:0]      dist_r, dist_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_low_r   <= LEAD_LOW_RST;
      trig_width_r <= TRIG_WIDTH_RST;
      start_to_r   <= START_TO_RST;
      echo_to_r    <= ECHO_TO_RST;
      us_per_cm_r  <= US_PER_CM_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LEAD_LOW:   lead_low_r   <= cfg_wdata[7:0];
        REG_TRIG_WIDTH: trig_width_r <= cfg_wdata[7:0];
        REG_START_TO:   start_to_r   <= cfg_wdata[15:0];
        REG_ECHO_TO:    echo_to_r    <= cfg_wdata[15:0];
        REG_US_PER_CM:  us_per_cm_r  <= cfg_wdata[DIVISOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturating count of one microsecond and the limit compares on it.
  assign elapsed_inc = (elapsed_r == CNT_MAX) ? elapsed_r : elapsed_r + COUNT_WIDTH'(1);

  always_comb begin
    dp_status.lead_zero = (lead_low_r == 8'd0);
    dp_status.lead_hit  = CMP_W'(elapsed_inc) >= CMP_W'(lead_low_r);
    dp_status.pulse_hit = CMP_W'(elapsed_inc) >= CMP_W'(trig_width_r);
    dp_status.rise_to   = (CMP_W'(elapsed_inc) >= CMP_W'(start_to_r)) ||
                          (elapsed_inc == CNT_MAX);
    dp_status.high_to   = (CMP_W'(elapsed_inc) >= CMP_W'(echo_to_r)) ||
                          (elapsed_inc == CNT_MAX);
    dp_status.first_to  = (echo_to_r <= 16'd1);
    dp_status.div_done  = div_busy_r && (div_cnt_r == '0);
  end

  always_comb begin
    case (dp_cmd.cnt_op)
      CNT_HOLD:  elapsed_nxt = elapsed_r;
      CNT_INC:   elapsed_nxt = elapsed_inc;
      CNT_CLEAR: elapsed_nxt = '0;
      CNT_ONE:   elapsed_nxt = COUNT_WIDTH'(1);
      default:   elapsed_nxt = elapsed_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else begin
      elapsed_r <= elapsed_nxt;
    end
  end

  // Restoring divider, one quotient bit per cycle.
  assign rem_sh   = {rem_r, quo_r[COUNT_WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, us_per_cm_r};
  assign rem_ge   = rem_sh >= {1'b0, us_per_cm_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (dp_cmd.div_start) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= DIV_CNT_W'(COUNT_WIDTH);
    end else if (div_busy_r) begin
      if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
      end else begin
        div_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.div_start) begin
      quo_r <= elapsed_r;
      rem_r <= '0;
    end else if (div_busy_r && (div_cnt_r != '0)) begin
      quo_r <= {quo_r[COUNT_WIDTH-2:0], rem_ge};
      rem_r <= rem_ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end
  end

  // Result register.
  always_comb begin
    if (!dp_cmd.res_quot) begin
      dist_nxt = '0;
    end else if (us_per_cm_r == '0) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = sat_dist(quo_r);
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.out_load) begin
      trig_r   <= dp_cmd.res_trig;
      busy_r   <= dp_cmd.res_busy;
      done_r   <= dp_cmd.res_done;
      status_r <= dp_cmd.res_status;
      dist_r   <= dist_nxt;
    end
  end

  assign res_trigger_level = trig_r;
  assign res_busy          = busy_r;
  assign res_done          = done_r;
  assign res_status        = status_r;
  assign res_distance_cm   = dist_r;

endmodule

/* hdl/ultrasonic_echo_ranger_top.sv */
// Top level of the ultrasonic echo ranger: controller plus datapath.
// Depends on uer_pkg, uer_if, uer_ctrl and uer_dp.
//
// Usage: each request on in_ch is either a one-microsecond tick (cmd 0)
// carrying the sampled echo level, or a start command (cmd 1). Every
// request produces exactly one result on out_ch with the trigger level to
// drive, the busy flag, and on the request that ends a measurement the
// done flag, a status and the distance in centimeters.
// A result is registered in the cycle after its request, except for
// the tick on which echo falls: that one runs the one-bit-per-cycle divider
// over the COUNT_WIDTH-bit count, and its result is loaded into the output
// register when the divider is done. The divider sets the worst case.
// Throughput: one request per cycle while results are taken at once; in_ch
// holds ready low during a division and while an untaken result sits in
// the output register, so a stalled receiver stalls the sender.
// Reset (rst_n low, synchronous) returns the block to idle, clears the
// count and the output slot, and loads the default register values.
// Configuration writes on cfg_we/cfg_idx/cfg_wdata take effect at once.
module ultrasonic_echo_ranger_top import uer_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  uer_in_if.sink                in_ch,
  uer_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       in_ready;
  logic       out_valid;

  // Controller: phase sequencing and handshakes.
  uer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_echo   (in_ch.echo_level),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

  // Datapath: counter, compares, divider and result register.
  uer_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .dp_cmd            (dp_cmd),
    .dp_status         (dp_status),
    .res_trigger_level (out_ch.trigger_level),
    .res_busy          (out_ch.busy_res),
    .res_done          (out_ch.done_res),
    .res_status        (out_ch.status),
    .res_distance_cm   (out_ch.distance_cm)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

/* hdl/uer_checker.sv */
// Port-level checks for the ultrasonic echo ranger, bound to the top level.
// Depends on uer_pkg and ultrasonic_echo_ranger_top_assert.svh.
`include "ultrasonic_echo_ranger_top_assert.svh"

module uer_checker import uer_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_trigger_level,
  input logic                out_busy_res,
  input logic                out_done_res,
  input logic [STATUS_W-1:0] out_status,
  input logic [DIST_W-1:0]   out_distance_cm
);

  // A finished measurement leaves the block idle with trigger released.
  `UER_ASSERT_NOW(a_done_idle, clk, rst_n, out_valid && out_done_res, !out_busy_res && !out_trigger_level, "done result still busy")

  // Results that end nothing carry no status and no distance.
  `UER_ASSERT_NOW(a_plain_zero, clk, rst_n, out_valid && !out_done_res, (out_status == ST_OK) && (out_distance_cm == '0), "status or distance without done")

  // Error results carry no distance.
  `UER_ASSERT_NOW(a_err_nodist, clk, rst_n, out_valid && out_done_res && (out_status != ST_OK), out_distance_cm == '0, "distance on error result")

  // A stalled result holds.
  `UER_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_distance_cm) && $stable(out_status), "stalled result changed")

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_trigger_level (out_ch.trigger_level),
  .out_busy_res      (out_ch.busy_res),
  .out_done_res      (out_ch.done_res),
  .out_status        (out_ch.status),
  .out_distance_cm   (out_ch.distance_cm)
);
